[rtl/psv_pkg.sv]
package psv_pkg;

	typedef enum logic [2:0] {
		MODE_ACTIVE = 3'b001,
		MODE_SAVE   = 3'b010,
		MODE_FAULT  = 3'b100
	} mode_t;

	localparam logic [1:0] MODE_CODE_ACTIVE = 2'd0;
	localparam logic [1:0] MODE_CODE_SAVE   = 2'd1;
	localparam logic [1:0] MODE_CODE_FAULT  = 2'd2;

	localparam logic [1:0] STATUS_OK   = 2'd1;
	localparam logic [1:0] STATUS_FAIL = 2'd2;

	localparam logic [1:0] CFG_FAULT_TEMP = 2'd0;
	localparam logic [1:0] CFG_IDLE_TICKS = 2'd1;
	localparam logic [1:0] CFG_SCAN_TICKS = 2'd2;
	localparam logic [1:0] CFG_DEBOUNCE   = 2'd3;

	localparam logic signed [7:0] RESET_FAULT_TEMP = 8'sd27;
	localparam logic [15:0] RESET_IDLE_TICKS = 16'd5000;
	localparam logic [7:0]  RESET_SCAN_TICKS = 8'd10;
	localparam logic [3:0]  RESET_DEBOUNCE   = 4'd3;

	localparam logic [15:0] IDLE_MAX   = 16'hFFFF;
	localparam logic [3:0]  DIGIT_LAST = 4'd9;
	localparam logic [7:0]  SEG_BLANK  = 8'hFF;

	function automatic logic [7:0] seg_code(input logic [3:0] d);
		logic [7:0] s;
		case (d)
			4'd0: s = 8'hC0;
			4'd1: s = 8'hF9;
			4'd2: s = 8'hA4;
			4'd3: s = 8'hB0;
			4'd4: s = 8'h99;
			4'd5: s = 8'h92;
			4'd6: s = 8'h82;
			4'd7: s = 8'hF8;
			4'd8: s = 8'h80;
			4'd9: s = 8'h90;
			default: s = SEG_BLANK;
		endcase
		return s;
	endfunction

	function automatic logic [1:0] mode_code(input mode_t m);
		logic [1:0] c;
		case (m)
			MODE_ACTIVE: c = MODE_CODE_ACTIVE;
			MODE_SAVE:   c = MODE_CODE_SAVE;
			MODE_FAULT:  c = MODE_CODE_FAULT;
			default:     c = MODE_CODE_ACTIVE;
		endcase
		return c;
	endfunction

endpackage

[rtl/power_supervisor_fsm.sv]
// channel | signals                                         | direction
// in      | in_valid/in_ready, key/load/temp/status fields  | input words, one per tick
// out     | out_valid/out_ready, mode..status_fault         | result words, one per input
// cfg     | cfg_valid/cfg_ready, cfg_index, cfg_data        | register writes, always ready
//
// Each word passes an input register and one pass of compare/count logic into the
// result register: the word waits in the input register until the result register can take it,
// and one word per cycle flows while out_ready stays high.
// A waiting result holds the input register; in_ready drops once both hold a word and out_ready is low.
// Reset returns the mode machine, counters, flags, valid bits and config registers to their defaults.
module power_supervisor_fsm (
	input  logic               clk,
	input  logic               arst_n,
	input  logic               in_valid,
	output logic               in_ready,
	input  logic               key_pressed,
	input  logic               load_flag,
	input  logic               temp_valid,
	input  logic signed [15:0] temp_raw,
	input  logic [1:0]         status_result,
	input  logic [15:0]        status_data,
	output logic               out_valid,
	input  logic               out_ready,
	output logic [1:0]         mode,
	output logic [3:0]         digit,
	output logic [7:0]         seg_pattern,
	output logic               press_event,
	output logic               clear_faults_cmd,
	output logic signed [11:0] temp_celsius,
	output logic               status_fault,
	input  logic               cfg_valid,
	output logic               cfg_ready,
	input  logic [1:0]         cfg_index,
	input  logic [15:0]        cfg_data
);

	logic signed [7:0] fault_temp_q;
	logic [15:0]       idle_ticks_q;
	logic [7:0]        scan_ticks_q;
	logic [3:0]        debounce_q;

	psv_pkg::mode_t    mode_q, mode_d;
	logic [3:0]        press_q, press_d;
	logic [7:0]        scan_q, scan_d;
	logic              stable_q, stable_d;
	logic              last_q, last_d;
	logic [3:0]        agree_q, agree_d;
	logic [15:0]       idle_q, idle_d;
	logic signed [11:0] temp_q, temp_d;
	logic              fault_q, fault_d;

	logic              valid_s1;
	logic              key_s1, load_s1, tvalid_s1;
	logic signed [15:0] traw_s1;
	logic [1:0]        status_s1;
	logic [15:0]       sword_s1;

	logic              out_valid_q;
	logic [1:0]        mode_out_q;
	logic [3:0]        digit_q;
	logic [7:0]        seg_q;
	logic              event_q, clear_q;
	logic signed [11:0] temp_out_q;
	logic              fault_out_q;

	logic              advance;
	logic              in_fire;
	logic              ev, clr, hot, level;
	logic [8:0]        scan_inc;
	logic signed [16:0] traw_adj;
	logic [3:0]        press_inc;

	assign advance   = valid_s1 && (!out_valid_q || out_ready);
	assign in_ready  = !valid_s1 || advance;
	assign in_fire   = in_valid && in_ready;
	assign cfg_ready = 1'b1;

	assign scan_inc  = {1'b0, scan_q} + 9'd1;
	assign traw_adj  = {traw_s1[15], traw_s1} + (traw_s1[15] ? 17'sd15 : 17'sd0);
	assign press_inc = (press_q == psv_pkg::DIGIT_LAST) ? 4'd0 : press_q + 4'd1;

	always_comb begin
		scan_d   = scan_q;
		agree_d  = agree_q;
		last_d   = last_q;
		stable_d = stable_q;
		ev       = 1'b0;
		level    = !key_s1;
		if (scan_inc >= {1'b0, scan_ticks_q}) begin
			scan_d = 8'd0;
			if (level == last_q) begin
				if (agree_q < debounce_q) begin
					agree_d = agree_q + 4'd1;
				end
			end else begin
				agree_d = 4'd0;
				last_d  = level;
			end
			if (agree_d >= debounce_q && stable_q != level) begin
				stable_d = level;
				ev       = !level;
			end
		end else begin
			scan_d = scan_inc[7:0];
		end

		temp_d = tvalid_s1 ? traw_adj[15:4] : temp_q;

		fault_d = fault_q;
		if (status_s1 == psv_pkg::STATUS_OK) begin
			fault_d = |sword_s1;
		end else if (status_s1 == psv_pkg::STATUS_FAIL) begin
			fault_d = 1'b0;
		end

		hot     = temp_d >= 12'(fault_temp_q);
		mode_d  = mode_q;
		press_d = press_q;
		idle_d  = idle_q;
		clr     = 1'b0;
		case (mode_q)
			psv_pkg::MODE_ACTIVE: begin
				if (hot || fault_d) begin
					mode_d = psv_pkg::MODE_FAULT;
				end else begin
					if (idle_q != psv_pkg::IDLE_MAX) begin
						idle_d = idle_q + 16'd1;
					end
					if (ev) begin
						press_d = press_inc;
					end
					if (ev || load_s1) begin
						idle_d = 16'd0;
					end
					if (idle_d >= idle_ticks_q) begin
						mode_d = psv_pkg::MODE_SAVE;
					end
				end
			end
			psv_pkg::MODE_SAVE: begin
				if (hot || fault_d) begin
					mode_d = psv_pkg::MODE_FAULT;
				end else if (load_s1 || ev) begin
					if (ev) begin
						press_d = press_inc;
					end
					mode_d = psv_pkg::MODE_ACTIVE;
					idle_d = 16'd0;
				end
			end
			psv_pkg::MODE_FAULT: begin
				if (ev) begin
					clr     = 1'b1;
					fault_d = 1'b0;
					mode_d  = psv_pkg::MODE_ACTIVE;
					idle_d  = 16'd0;
				end
			end
			default: begin
				mode_d = psv_pkg::MODE_ACTIVE;
				idle_d = 16'd0;
			end
		endcase
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			fault_temp_q <= psv_pkg::RESET_FAULT_TEMP;
			idle_ticks_q <= psv_pkg::RESET_IDLE_TICKS;
			scan_ticks_q <= psv_pkg::RESET_SCAN_TICKS;
			debounce_q   <= psv_pkg::RESET_DEBOUNCE;
		end else if (cfg_valid) begin
			case (cfg_index)
				psv_pkg::CFG_FAULT_TEMP: fault_temp_q <= cfg_data[7:0];
				psv_pkg::CFG_IDLE_TICKS: idle_ticks_q <= cfg_data;
				psv_pkg::CFG_SCAN_TICKS: scan_ticks_q <= cfg_data[7:0];
				psv_pkg::CFG_DEBOUNCE:   debounce_q   <= cfg_data[3:0];
				default: ;
			endcase
		end
	end

	// hold the input word until the result register frees up
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_s1 <= 1'b0;
		end else if (in_ready) begin
			valid_s1 <= in_valid;
		end
	end

	always_ff @(posedge clk) begin
		if (in_fire) begin
			key_s1    <= key_pressed;
			load_s1   <= load_flag;
			tvalid_s1 <= temp_valid;
			traw_s1   <= temp_raw;
			status_s1 <= status_result;
			sword_s1  <= status_data;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			mode_q   <= psv_pkg::MODE_ACTIVE;
			press_q  <= 4'd0;
			scan_q   <= 8'd0;
			stable_q <= 1'b1;
			last_q   <= 1'b1;
			agree_q  <= 4'd0;
			idle_q   <= 16'd0;
			temp_q   <= 12'sd0;
			fault_q  <= 1'b0;
		end else if (advance) begin
			mode_q   <= mode_d;
			press_q  <= press_d;
			scan_q   <= scan_d;
			stable_q <= stable_d;
			last_q   <= last_d;
			agree_q  <= agree_d;
			idle_q   <= idle_d;
			temp_q   <= temp_d;
			fault_q  <= fault_d;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			out_valid_q <= 1'b0;
		end else if (advance) begin
			out_valid_q <= 1'b1;
		end else if (out_ready) begin
			out_valid_q <= 1'b0;
		end
	end

	always_ff @(posedge clk) begin
		if (advance) begin
			mode_out_q  <= psv_pkg::mode_code(mode_d);
			digit_q     <= press_d;
			seg_q       <= (mode_d == psv_pkg::MODE_ACTIVE) ?
				psv_pkg::seg_code(press_d) : psv_pkg::SEG_BLANK;
			event_q     <= ev;
			clear_q     <= clr;
			temp_out_q  <= temp_d;
			fault_out_q <= fault_d;
		end
	end

	assign out_valid        = out_valid_q;
	assign mode             = mode_out_q;
	assign digit            = digit_q;
	assign seg_pattern      = seg_q;
	assign press_event      = event_q;
	assign clear_faults_cmd = clear_q;
	assign temp_celsius     = temp_out_q;
	assign status_fault     = fault_out_q;

endmodule

[tb/tb_top.sv]
`timescale 1ns / 100ps

module tb_top;

	localparam logic [1:0] STATUS_NONE = 2'd0;
	localparam logic [1:0] STATUS_RSVD = 2'd3;
	localparam int QUIET_LIMIT = 2000;
	localparam int PHASES = 8;
	localparam int PHASE_WORDS = 88;

	typedef struct {
		logic key;
		logic load;
		logic temp_valid;
		logic signed [15:0] temp_raw;
		logic [1:0] status;
		logic [15:0] word;
	} tick_t;

	typedef struct {
		logic [1:0] mode;
		logic [3:0] digit;
		logic [7:0] seg;
		logic press_event;
		logic clear_cmd;
		logic signed [11:0] temp;
		logic fault;
	} tick_result_t;

	class supervisor_scoreboard;
		logic signed [7:0] fault_temp;
		logic [15:0] idle_limit;
		logic [7:0] scan_period;
		logic [3:0] debounce_need;

		logic [1:0] cur_mode;
		logic [3:0] press_digit;
		int scan_count;
		logic stable_level;
		logic last_level;
		logic [3:0] agree_count;
		logic [15:0] idle_count;
		int temp_whole;
		logic fault_flag;

		logic [7:0] seg_lut [10];
		tick_result_t expected_q[$];
		int errors;
		int checked;
		int key_events;
		int recoveries;
		int fault_entries;
		int save_entries;

		function new();
			seg_lut = '{8'hC0, 8'hF9, 8'hA4, 8'hB0, 8'h99, 8'h92, 8'h82, 8'hF8, 8'h80, 8'h90};
			fault_temp = psv_pkg::RESET_FAULT_TEMP;
			idle_limit = psv_pkg::RESET_IDLE_TICKS;
			scan_period = psv_pkg::RESET_SCAN_TICKS;
			debounce_need = psv_pkg::RESET_DEBOUNCE;
			cur_mode = psv_pkg::MODE_CODE_ACTIVE;
			press_digit = 4'd0;
			scan_count = 0;
			stable_level = 1'b1;
			last_level = 1'b1;
			agree_count = 4'd0;
			idle_count = 16'd0;
			temp_whole = 0;
			fault_flag = 1'b0;
			errors = 0;
			checked = 0;
			key_events = 0;
			recoveries = 0;
			fault_entries = 0;
			save_entries = 0;
		endfunction

		function void set_register(logic [1:0] idx, logic [15:0] data);
			case (idx)
				psv_pkg::CFG_FAULT_TEMP: fault_temp = data[7:0];
				psv_pkg::CFG_IDLE_TICKS: idle_limit = data;
				psv_pkg::CFG_SCAN_TICKS: scan_period = data[7:0];
				psv_pkg::CFG_DEBOUNCE: debounce_need = data[3:0];
				default: ;
			endcase
		endfunction

		function void bump_digit();
			press_digit = (press_digit == psv_pkg::DIGIT_LAST) ? 4'd0 : press_digit + 4'd1;
		endfunction

		function void note_input(tick_t w);
			tick_result_t r;
			logic lvl;
			logic ev;
			logic clr;
			logic hot;
			logic [1:0] prev_mode;
			ev = 1'b0;
			clr = 1'b0;
			prev_mode = cur_mode;
			if (scan_count + 1 >= int'(scan_period)) begin
				scan_count = 0;
				lvl = w.key ? 1'b0 : 1'b1;
				if (lvl == last_level) begin
					if (agree_count < debounce_need)
						agree_count++;
				end else begin
					agree_count = 4'd0;
					last_level = lvl;
				end
				if (agree_count >= debounce_need && stable_level != lvl) begin
					stable_level = lvl;
					ev = (lvl == 1'b0);
				end
			end else begin
				scan_count++;
			end
			if (w.temp_valid)
				temp_whole = int'(w.temp_raw) / 16;
			case (w.status)
				psv_pkg::STATUS_OK: fault_flag = (w.word != 16'd0);
				psv_pkg::STATUS_FAIL: fault_flag = 1'b0;
				default: ;
			endcase
			hot = (temp_whole >= int'(fault_temp));
			case (cur_mode)
				psv_pkg::MODE_CODE_ACTIVE: begin
					if (hot || fault_flag) begin
						cur_mode = psv_pkg::MODE_CODE_FAULT;
					end else begin
						if (idle_count != psv_pkg::IDLE_MAX)
							idle_count++;
						if (ev) begin
							bump_digit();
							idle_count = 16'd0;
						end
						if (w.load)
							idle_count = 16'd0;
						if (idle_count >= idle_limit)
							cur_mode = psv_pkg::MODE_CODE_SAVE;
					end
				end
				psv_pkg::MODE_CODE_SAVE: begin
					if (hot || fault_flag) begin
						cur_mode = psv_pkg::MODE_CODE_FAULT;
					end else if (w.load || ev) begin
						if (ev)
							bump_digit();
						cur_mode = psv_pkg::MODE_CODE_ACTIVE;
						idle_count = 16'd0;
					end
				end
				psv_pkg::MODE_CODE_FAULT: begin
					if (ev) begin
						clr = 1'b1;
						fault_flag = 1'b0;
						cur_mode = psv_pkg::MODE_CODE_ACTIVE;
						idle_count = 16'd0;
					end
				end
				default: begin
					cur_mode = psv_pkg::MODE_CODE_ACTIVE;
					idle_count = 16'd0;
				end
			endcase
			if (ev)
				key_events++;
			if (clr)
				recoveries++;
			if (cur_mode != prev_mode && cur_mode == psv_pkg::MODE_CODE_FAULT)
				fault_entries++;
			if (cur_mode != prev_mode && cur_mode == psv_pkg::MODE_CODE_SAVE)
				save_entries++;
			r.mode = cur_mode;
			r.digit = press_digit;
			r.seg = (cur_mode == psv_pkg::MODE_CODE_ACTIVE &&
				press_digit <= psv_pkg::DIGIT_LAST) ?
				seg_lut[press_digit] : psv_pkg::SEG_BLANK;
			r.press_event = ev;
			r.clear_cmd = clr;
			r.temp = 12'(temp_whole);
			r.fault = fault_flag;
			expected_q.push_back(r);
		endfunction

		function void check_result(tick_result_t got);
			tick_result_t want;
			if (expected_q.size() == 0) begin
				errors++;
				if (errors <= 10)
					$display("[%0t] result word arrived with nothing pending", $time);
				return;
			end
			want = expected_q.pop_front();
			checked++;
			if (got.mode !== want.mode || got.digit !== want.digit || got.seg !== want.seg ||
					got.press_event !== want.press_event ||
					got.clear_cmd !== want.clear_cmd ||
					got.temp !== want.temp || got.fault !== want.fault) begin
				errors++;
				if (errors <= 10) begin
					$display("[%0t] mismatch on word %0d", $time, checked);
					$display("  exp mode=%0d digit=%0d seg=%h key=%b clr=%b temp=%0d flt=%b",
						want.mode, want.digit, want.seg, want.press_event, want.clear_cmd,
						want.temp, want.fault);
					$display("  got mode=%0d digit=%0d seg=%h key=%b clr=%b temp=%0d flt=%b",
						got.mode, got.digit, got.seg, got.press_event, got.clear_cmd,
						got.temp, got.fault);
				end
			end
		endfunction

		function void close_out();
			if (expected_q.size() != 0) begin
				errors++;
				$display("%0d expected result words never arrived", expected_q.size());
			end
		endfunction
	endclass

	logic clk = 1'b0;
	logic arst_n = 1'b0;
	logic in_valid = 1'b0;
	logic in_ready;
	logic key_pressed = 1'b0;
	logic load_flag = 1'b0;
	logic temp_valid = 1'b0;
	logic signed [15:0] temp_raw = 16'sd0;
	logic [1:0] status_result = STATUS_NONE;
	logic [15:0] status_data = 16'd0;
	logic out_valid;
	logic out_ready = 1'b0;
	logic [1:0] mode;
	logic [3:0] digit;
	logic [7:0] seg_pattern;
	logic press_event;
	logic clear_faults_cmd;
	logic signed [11:0] temp_celsius;
	logic status_fault;
	logic cfg_valid = 1'b0;
	logic cfg_ready;
	logic [1:0] cfg_index = psv_pkg::CFG_FAULT_TEMP;
	logic [15:0] cfg_data = 16'd0;

	supervisor_scoreboard sb;
	int in_idle_pct = 0;
	int out_stall_pct = 0;
	int quiet_cycles = 0;
	int settings_seen = 1;
	int ph_thr = 27;
	logic [7:0] ph_scan = 8'd10;
	logic [3:0] ph_deb = 4'd3;
	int key_run = 0;
	logic key_level = 1'b0;

	power_supervisor_fsm dut (.*);

	always #10 clk = ~clk;

	always @(negedge clk)
		out_ready <= ($urandom_range(99) >= out_stall_pct);

	always @(posedge clk) begin
		if (arst_n) begin
			if (in_valid && in_ready)
				sb.note_input(tick_t'{key_pressed, load_flag, temp_valid, temp_raw,
					status_result, status_data});
			if (out_valid && out_ready)
				sb.check_result(tick_result_t'{mode, digit, seg_pattern, press_event,
					clear_faults_cmd, temp_celsius, status_fault});
			if ((in_valid && in_ready) || (out_valid && out_ready) || (cfg_valid && cfg_ready)) begin
				quiet_cycles <= 0;
			end else if (quiet_cycles >= QUIET_LIMIT) begin
				$display("no word moved for %0d cycles", QUIET_LIMIT);
				$display("FAILED: results differ");
				$finish;
			end else begin
				quiet_cycles <= quiet_cycles + 1;
			end
		end
	end

	task automatic set_idling(input int phase);
		case (phase % 4)
			0: begin in_idle_pct = 0; out_stall_pct = 0; end
			1: begin in_idle_pct = 46; out_stall_pct = 0; end
			2: begin in_idle_pct = 0; out_stall_pct = 46; end
			default: begin in_idle_pct = 20; out_stall_pct = 20; end
		endcase
	endtask

	task automatic send_word(input tick_t w);
		@(negedge clk);
		while ($urandom_range(99) < in_idle_pct) begin
			in_valid <= 1'b0;
			@(negedge clk);
		end
		in_valid <= 1'b1;
		key_pressed <= w.key;
		load_flag <= w.load;
		temp_valid <= w.temp_valid;
		temp_raw <= w.temp_raw;
		status_result <= w.status;
		status_data <= w.word;
		@(posedge clk);
		while (!in_ready)
			@(posedge clk);
	endtask

	task automatic tick(input logic key, input logic load, input logic tv,
			input logic signed [15:0] raw, input logic [1:0] st, input logic [15:0] word);
		tick_t w;
		w = '{key, load, tv, raw, st, word};
		send_word(w);
	endtask

	task automatic drain_results();
		@(negedge clk);
		in_valid <= 1'b0;
		while (sb.expected_q.size() != 0)
			@(posedge clk);
		repeat (4) @(posedge clk);
	endtask

	task automatic write_reg(input logic [1:0] idx, input logic [15:0] value);
		@(negedge clk);
		cfg_valid <= 1'b1;
		cfg_index <= idx;
		case (idx)
			psv_pkg::CFG_FAULT_TEMP: begin
				cfg_data <= {8'($urandom), value[7:0]};
				ph_thr = int'($signed(value[7:0]));
			end
			psv_pkg::CFG_SCAN_TICKS: begin
				cfg_data <= {8'($urandom), value[7:0]};
				ph_scan = value[7:0];
			end
			psv_pkg::CFG_DEBOUNCE: begin
				cfg_data <= {12'($urandom), value[3:0]};
				ph_deb = value[3:0];
			end
			default: cfg_data <= value;
		endcase
		@(posedge clk);
		while (!cfg_ready)
			@(posedge clk);
		sb.set_register(cfg_index, cfg_data);
		@(negedge clk);
		cfg_valid <= 1'b0;
	endtask

	function automatic tick_t random_word();
		tick_t w;
		int scan_eff;
		int raw;
		int pick;
		scan_eff = (ph_scan == 8'd0) ? 1 : int'(ph_scan);
		if (key_run == 0) begin
			key_level = ~key_level;
			if ($urandom_range(9) == 0)
				key_run = 1;
			else
				key_run = $urandom_range(scan_eff * (ph_deb + 1) + 2,
					scan_eff * (ph_deb + 2) * 2 + 4);
		end
		key_run--;
		w.key = key_level;
		w.load = ($urandom_range(99) < 4);
		w.temp_valid = ($urandom_range(99) < 15);
		pick = $urandom_range(99);
		if (pick < 70)
			raw = (ph_thr - int'($urandom_range(1, 20))) * 16 + int'($urandom_range(15));
		else if (pick < 85)
			raw = (ph_thr + int'($urandom_range(3))) * 16 + int'($urandom_range(15));
		else
			raw = int'($urandom_range(65535));
		w.temp_raw = 16'(raw);
		pick = $urandom_range(99);
		w.word = (pick < 3) ? 16'h0000 : 16'($urandom);
		if (pick < 5)
			w.status = psv_pkg::STATUS_OK;
		else if (pick < 9)
			w.status = psv_pkg::STATUS_FAIL;
		else if (pick < 11)
			w.status = STATUS_RSVD;
		else
			w.status = STATUS_NONE;
		return w;
	endfunction

	initial begin
		int ph;
		int n;
		int pick;
		sb = new();
		set_idling(0);
		repeat (11) @(posedge clk);
		@(negedge clk);
		arst_n <= 1'b1;

		// reset settings: temperature extremes, truncation, status codes
		tick(1'b0, 1'b0, 1'b1, 16'h8000, STATUS_NONE, 16'h0000);
		tick(1'b0, 1'b0, 1'b1, 16'hFFFF, STATUS_NONE, 16'h0000);
		tick(1'b0, 1'b0, 1'b1, 16'hFFEF, STATUS_NONE, 16'h0000);
		tick(1'b0, 1'b0, 1'b1, 16'h7FFF, STATUS_NONE, 16'h0000);
		tick(1'b0, 1'b1, 1'b0, 16'h1234, psv_pkg::STATUS_OK, 16'hFFFF);
		tick(1'b0, 1'b0, 1'b0, 16'h0000, psv_pkg::STATUS_FAIL, 16'hFFFF);
		tick(1'b0, 1'b0, 1'b0, 16'h0000, STATUS_RSVD, 16'hFFFF);
		tick(1'b0, 1'b0, 1'b1, 16'h0000, STATUS_NONE, 16'h0000);
		drain_results();

		// scan every tick, no debounce, zero timeout, top threshold
		write_reg(psv_pkg::CFG_SCAN_TICKS, 16'd0);
		write_reg(psv_pkg::CFG_DEBOUNCE, 16'd0);
		write_reg(psv_pkg::CFG_IDLE_TICKS, 16'd0);
		write_reg(psv_pkg::CFG_FAULT_TEMP, 16'd127);
		settings_seen++;
		tick(1'b1, 1'b0, 1'b0, 16'h0000, STATUS_NONE, 16'h0000);
		tick(1'b0, 1'b0, 1'b0, 16'h0000, STATUS_NONE, 16'h0000);
		tick(1'b0, 1'b1, 1'b0, 16'h0000, STATUS_NONE, 16'h0000);
		tick(1'b1, 1'b0, 1'b0, 16'h0000, STATUS_NONE, 16'h0000);
		tick(1'b0, 1'b0, 1'b0, 16'h0000, STATUS_NONE, 16'h0000);
		tick(1'b1, 1'b0, 1'b0, 16'h0000, STATUS_NONE, 16'h0000);
		tick(1'b0, 1'b0, 1'b0, 16'h0000, psv_pkg::STATUS_OK, 16'h8000);
		tick(1'b1, 1'b0, 1'b0, 16'h0000, psv_pkg::STATUS_FAIL, 16'h0000);
		tick(1'b0, 1'b1, 1'b0, 16'h0000, STATUS_NONE, 16'h0000);
		tick(1'b1, 1'b0, 1'b1, 16'd2032, STATUS_NONE, 16'h0000);
		tick(1'b0, 1'b0, 1'b1, 16'h0000, STATUS_NONE, 16'h0000);
		tick(1'b1, 1'b0, 1'b0, 16'h0000, STATUS_NONE, 16'h0000);
		tick(1'b0, 1'b0, 1'b1, 16'h7FFF, STATUS_NONE, 16'h0000);
		tick(1'b1, 1'b0, 1'b0, 16'h0000, STATUS_NONE, 16'h0000);
		tick(1'b0, 1'b0, 1'b0, 16'h0000, STATUS_NONE, 16'h0000);
		drain_results();

		// widest register values
		write_reg(psv_pkg::CFG_IDLE_TICKS, 16'hFFFF);
		write_reg(psv_pkg::CFG_SCAN_TICKS, 16'd255);
		write_reg(psv_pkg::CFG_DEBOUNCE, 16'd15);
		write_reg(psv_pkg::CFG_FAULT_TEMP, 16'h0080);
		settings_seen++;
		tick(1'b1, 1'b1, 1'b1, 16'h8000, STATUS_NONE, 16'h0000);
		tick(1'b0, 1'b0, 1'b0, 16'h0000, STATUS_NONE, 16'h0000);

		for (ph = 0; ph < PHASES; ph++) begin
			drain_results();
			write_reg(psv_pkg::CFG_FAULT_TEMP, 16'($urandom_range(180) - 55));
			pick = $urandom_range(9);
			if (pick == 0)
				write_reg(psv_pkg::CFG_IDLE_TICKS, 16'd0);
			else if (pick == 1)
				write_reg(psv_pkg::CFG_IDLE_TICKS, 16'hFFFF);
			else
				write_reg(psv_pkg::CFG_IDLE_TICKS, 16'($urandom_range(1, 40)));
			write_reg(psv_pkg::CFG_SCAN_TICKS,
				($urandom_range(9) == 0) ? 16'd0 : 16'($urandom_range(1, 4)));
			write_reg(psv_pkg::CFG_DEBOUNCE,
				($urandom_range(9) == 0) ? 16'd0 : 16'($urandom_range(1, 4)));
			settings_seen++;
			key_run = 0;
			set_idling(ph);
			for (n = 0; n < PHASE_WORDS; n++)
				send_word(random_word());
		end
		drain_results();
		sb.close_out();

		$display("Checked %0d result words under %0d register settings", sb.checked, settings_seen);
		$display("  %0d key presses, %0d power-save entries, %0d fault entries, %0d recoveries",
			sb.key_events, sb.save_entries, sb.fault_entries, sb.recoveries);
		if (sb.errors == 0)
			$display("PASSED: all results match");
		else
			$display("FAILED: results differ");
		$finish;
	end

endmodule

[power_supervisor_fsm.f]
rtl/psv_pkg.sv
rtl/power_supervisor_fsm.sv
tb/tb_top.sv
